[sv/lplm_pkg.sv]
// Package for the line packet link monitor.
// Holds reset values of the configuration registers, character codes, result codes
// and register indexes. No dependencies.
package lplm_pkg;

    // Default width of the line length counter
    localparam int LINE_LEN_BITS_DEF = 10;

    // Configuration register widths and reset values
    localparam int MAX_LEN_W  = 10;
    localparam int TICK_W     = 16;
    localparam int CFG_DATA_W = 16;

    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 10'd640;
    localparam logic [TICK_W-1:0]    TIMEOUT_RESET = 16'd3500;
    localparam logic [TICK_W-1:0]    POLL_RESET    = 16'd1200;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MAX_LINE_LENGTH = 2'd0,
        CFG_TIMEOUT_TICKS   = 2'd1,
        CFG_POLL_PERIOD     = 2'd2
    } cfg_index_t;

    // Request types
    typedef enum logic {
        REQ_BYTE = 1'b0,
        REQ_TICK = 1'b1
    } req_type_t;

    // Line event codes
    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_GOOD = 2'd1,
        EV_BAD  = 2'd2
    } line_event_t;

    // Packet kinds
    typedef enum logic [1:0] {
        KIND_STS = 2'd0,
        KIND_ACK = 2'd1,
        KIND_ERR = 2'd2,
        KIND_ALM = 2'd3
    } packet_kind_t;

    // Character codes
    localparam logic [7:0] CH_LF        = 8'd10;
    localparam logic [7:0] CH_CR        = 8'd13;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_PRINT_MAX = 8'd126;

    // Packet type words, first character in the top byte
    localparam logic [23:0] WORD_STS = {8'h53, 8'h54, 8'h53};
    localparam logic [23:0] WORD_ACK = {8'h41, 8'h43, 8'h4B};
    localparam logic [23:0] WORD_ERR = {8'h45, 8'h52, 8'h52};
    localparam logic [23:0] WORD_ALM = {8'h41, 8'h4C, 8'h4D};

endpackage

[sv/line_packet_link_monitor.sv]
// Line packet link monitor: line assembly, packet check, counters and link timers.
// Single module; depends on lplm_pkg.
//
// Usage: the s_ channel carries one item per handshake, either a received byte
// (s_req_type = 0) or a one millisecond tick (s_req_type = 1). Every item gives
// exactly one result item on the m_ channel with the line event, tick events,
// link flags and the packet counters after that item.
// The cfg_ channel writes max_line_length (index 0), timeout_ticks (index 1) and
// poll_period (index 2) from cfg_data; other indexes are ignored. cfg_ready is
// always high; write only while no item is in flight.
// Each item is held in the input register, then its result in the result register on m_.
// Throughput: one item per cycle while the receiver does not stall; the single pass
// of next state logic between the two registers sets that rate.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; s_ready then drops until m_ready returns.
// Reset (aresetn low, synchronous) empties both registers, loads the default
// configuration and clears the line, timers, link flags and counters.
module line_packet_link_monitor
    import lplm_pkg::*;
#(
    parameter int LINE_LEN_BITS = LINE_LEN_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_req_type,
    input  logic [7:0]            s_rx_byte,
    // result items
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_line_event,
    output logic [1:0]            m_packet_kind,
    output logic                  m_poll_request,
    output logic                  m_swap_request,
    output logic                  m_link_lost,
    output logic                  m_connected,
    output logic                  m_status_live,
    output logic [31:0]           m_good_count,
    output logic [31:0]           m_bad_count,
    output logic [31:0]           m_bad_since_good,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CMP_W = (LINE_LEN_BITS > MAX_LEN_W) ? LINE_LEN_BITS : MAX_LEN_W;

    // Configuration registers
    logic [MAX_LEN_W-1:0] max_line_length_reg;
    logic [TICK_W-1:0]    timeout_ticks_reg;
    logic [TICK_W-1:0]    poll_period_reg;

    // Input register
    logic       in_valid_reg;
    logic       in_type_reg;
    logic [7:0] in_byte_reg;

    // Line state
    logic [LINE_LEN_BITS-1:0] line_length_reg, line_length_next;
    logic                     noise_flag_reg, noise_flag_next;
    logic                     content_seen_reg, content_seen_next;
    logic                     colon_found_reg, colon_found_next;
    logic [23:0]              type_chars_reg, type_chars_next;
    logic [2:0]               type_count_reg, type_count_next;

    // Link state
    logic [31:0] ticks_since_start_reg, ticks_since_start_next;
    logic [31:0] ticks_since_good_reg, ticks_since_good_next;
    logic [15:0] ticks_since_poll_reg, ticks_since_poll_next;
    logic        ever_good_reg, ever_good_next;
    logic        no_link_reported_reg, no_link_reported_next;
    logic        probe_done_reg, probe_done_next;
    logic        link_up_reg, link_up_next;
    logic        live_flag_reg, live_flag_next;
    logic [31:0] good_total_reg, good_total_next;
    logic [31:0] bad_total_reg, bad_total_next;
    logic [31:0] bad_run_reg, bad_run_next;

    // Result register
    logic        m_valid_reg;
    line_event_t event_reg, event_next;
    logic [1:0]  kind_reg, kind_next;
    logic        poll_reg, poll_next;
    logic        swap_reg, swap_next;
    logic        lost_reg, lost_next;
    logic        conn_reg;
    logic        live_reg;
    logic [31:0] good_out_reg;
    logic [31:0] bad_out_reg;
    logic [31:0] run_out_reg;

    // Pipeline control
    logic advance;
    logic step;
    logic s_accept;

    // Helpers for the step logic
    logic        type_ok;
    logic [1:0]  type_kind;
    logic        overflow;
    logic [31:0] tss_inc;
    logic [31:0] tsg_inc;
    logic [15:0] tsp_inc;
    logic [16:0] probe_limit;

    assign advance   = !m_valid_reg || m_ready;
    assign step      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Decode the packet type word
    always_comb begin
        type_ok   = 1'b0;
        type_kind = KIND_STS;
        if (colon_found_reg && type_count_reg == 3'd3) begin
            if (type_chars_reg == WORD_STS) begin
                type_ok   = 1'b1;
                type_kind = KIND_STS;
            end else if (type_chars_reg == WORD_ACK) begin
                type_ok   = 1'b1;
                type_kind = KIND_ACK;
            end else if (type_chars_reg == WORD_ERR) begin
                type_ok   = 1'b1;
                type_kind = KIND_ERR;
            end else if (type_chars_reg == WORD_ALM) begin
                type_ok   = 1'b1;
                type_kind = KIND_ALM;
            end
        end
    end

    // Line full check and saturating tick counters
    assign overflow = (CMP_W'(line_length_reg) >= CMP_W'(max_line_length_reg))
                      || (line_length_reg == {LINE_LEN_BITS{1'b1}});
    assign tss_inc  = (ticks_since_start_reg == 32'hFFFF_FFFF) ? ticks_since_start_reg
                      : ticks_since_start_reg + 32'd1;
    assign tsg_inc  = (ticks_since_good_reg == 32'hFFFF_FFFF) ? ticks_since_good_reg
                      : ticks_since_good_reg + 32'd1;
    assign tsp_inc  = (ticks_since_poll_reg == 16'hFFFF) ? ticks_since_poll_reg
                      : ticks_since_poll_reg + 16'd1;
    assign probe_limit = {timeout_ticks_reg, 1'b0};

    // Next state and result for the item in the input register
    always_comb begin
        line_length_next       = line_length_reg;
        noise_flag_next        = noise_flag_reg;
        content_seen_next      = content_seen_reg;
        colon_found_next       = colon_found_reg;
        type_chars_next        = type_chars_reg;
        type_count_next        = type_count_reg;
        ticks_since_start_next = ticks_since_start_reg;
        ticks_since_good_next  = ticks_since_good_reg;
        ticks_since_poll_next  = ticks_since_poll_reg;
        ever_good_next         = ever_good_reg;
        no_link_reported_next  = no_link_reported_reg;
        probe_done_next        = probe_done_reg;
        link_up_next           = link_up_reg;
        live_flag_next         = live_flag_reg;
        good_total_next        = good_total_reg;
        bad_total_next         = bad_total_reg;
        bad_run_next           = bad_run_reg;
        event_next             = EV_NONE;
        kind_next              = KIND_STS;
        poll_next              = 1'b0;
        swap_next              = 1'b0;
        lost_next              = 1'b0;

        if (in_type_reg == REQ_BYTE) begin
            if (in_byte_reg == CH_LF) begin
                // End of line: clear the line, then classify it
                line_length_next  = '0;
                content_seen_next = 1'b0;
                colon_found_next  = 1'b0;
                type_chars_next   = '0;
                type_count_next   = '0;
                noise_flag_next   = 1'b0;
                if (content_seen_reg && !noise_flag_reg && type_ok) begin
                    event_next            = EV_GOOD;
                    kind_next             = type_kind;
                    ticks_since_good_next = '0;
                    ever_good_next        = 1'b1;
                    bad_run_next          = '0;
                    no_link_reported_next = 1'b0;
                    link_up_next          = 1'b1;
                    if (type_kind == KIND_STS) begin
                        live_flag_next = 1'b1;
                    end
                    good_total_next = good_total_reg + 32'd1;
                end else if (content_seen_reg || noise_flag_reg) begin
                    event_next     = EV_BAD;
                    bad_run_next   = bad_run_reg + 32'd1;
                    bad_total_next = bad_total_reg + 32'd1;
                end
            end else if (in_byte_reg == CH_CR) begin
                // Drop carriage returns
            end else if (in_byte_reg < CH_SPACE || in_byte_reg > CH_PRINT_MAX) begin
                noise_flag_next = 1'b1;
            end else if (overflow) begin
                // Line too long: drop it and mark noise
                line_length_next  = '0;
                content_seen_next = 1'b0;
                colon_found_next  = 1'b0;
                type_chars_next   = '0;
                type_count_next   = '0;
                noise_flag_next   = 1'b1;
            end else begin
                line_length_next = line_length_reg + 1'b1;
                if (content_seen_reg || in_byte_reg != CH_SPACE) begin
                    content_seen_next = 1'b1;
                    if (!colon_found_reg) begin
                        if (in_byte_reg == CH_COLON) begin
                            colon_found_next = 1'b1;
                        end else begin
                            if (type_count_reg < 3'd3) begin
                                type_chars_next = {type_chars_reg[15:0], in_byte_reg};
                            end
                            if (type_count_reg < 3'd4) begin
                                type_count_next = type_count_reg + 3'd1;
                            end
                        end
                    end
                end
            end
        end else begin
            // Tick: advance timers, then poll, probe and link checks
            ticks_since_start_next = tss_inc;
            ticks_since_good_next  = tsg_inc;
            ticks_since_poll_next  = tsp_inc;

            if (tsp_inc >= poll_period_reg) begin
                ticks_since_poll_next = '0;
                poll_next             = 1'b1;
            end

            if (!probe_done_reg && !ever_good_reg && tss_inc >= 32'(probe_limit)) begin
                probe_done_next        = 1'b1;
                swap_next              = 1'b1;
                line_length_next       = '0;
                content_seen_next      = 1'b0;
                colon_found_next       = 1'b0;
                type_chars_next        = '0;
                type_count_next        = '0;
                noise_flag_next        = 1'b0;
                bad_run_next           = '0;
                ticks_since_start_next = '0;
                no_link_reported_next  = 1'b0;
                link_up_next           = 1'b0;
                live_flag_next         = 1'b0;
            end

            if (!ever_good_reg) begin
                if (!no_link_reported_next
                    && ticks_since_start_next > 32'(timeout_ticks_reg)) begin
                    no_link_reported_next = 1'b1;
                    link_up_next          = 1'b0;
                    live_flag_next        = 1'b0;
                    lost_next             = 1'b1;
                end
            end else if (tsg_inc > 32'(timeout_ticks_reg) && link_up_reg) begin
                link_up_next   = 1'b0;
                live_flag_next = 1'b0;
                lost_next      = 1'b1;
            end
        end
    end

    // Control state, configuration and link state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_line_length_reg   <= MAX_LEN_RESET;
            timeout_ticks_reg     <= TIMEOUT_RESET;
            poll_period_reg       <= POLL_RESET;
            in_valid_reg          <= 1'b0;
            m_valid_reg           <= 1'b0;
            line_length_reg       <= '0;
            noise_flag_reg        <= 1'b0;
            content_seen_reg      <= 1'b0;
            colon_found_reg       <= 1'b0;
            type_chars_reg        <= '0;
            type_count_reg        <= '0;
            ticks_since_start_reg <= '0;
            ticks_since_good_reg  <= '0;
            ticks_since_poll_reg  <= '0;
            ever_good_reg         <= 1'b0;
            no_link_reported_reg  <= 1'b0;
            probe_done_reg        <= 1'b0;
            link_up_reg           <= 1'b0;
            live_flag_reg         <= 1'b0;
            good_total_reg        <= '0;
            bad_total_reg         <= '0;
            bad_run_reg           <= '0;
        end else begin
            // Configuration writes
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_MAX_LINE_LENGTH: max_line_length_reg <= cfg_data[MAX_LEN_W-1:0];
                    CFG_TIMEOUT_TICKS:   timeout_ticks_reg   <= cfg_data[TICK_W-1:0];
                    CFG_POLL_PERIOD:     poll_period_reg     <= cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end

            // Input register occupancy
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            // Result register occupancy
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end

            // Commit the item's state change
            if (step) begin
                line_length_reg       <= line_length_next;
                noise_flag_reg        <= noise_flag_next;
                content_seen_reg      <= content_seen_next;
                colon_found_reg       <= colon_found_next;
                type_chars_reg        <= type_chars_next;
                type_count_reg        <= type_count_next;
                ticks_since_start_reg <= ticks_since_start_next;
                ticks_since_good_reg  <= ticks_since_good_next;
                ticks_since_poll_reg  <= ticks_since_poll_next;
                ever_good_reg         <= ever_good_next;
                no_link_reported_reg  <= no_link_reported_next;
                probe_done_reg        <= probe_done_next;
                link_up_reg           <= link_up_next;
                live_flag_reg         <= live_flag_next;
                good_total_reg        <= good_total_next;
                bad_total_reg         <= bad_total_next;
                bad_run_reg           <= bad_run_next;
            end
        end
    end

    // Payload of the input and result registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_type_reg <= s_req_type;
            in_byte_reg <= s_rx_byte;
        end
        if (step) begin
            event_reg    <= event_next;
            kind_reg     <= kind_next;
            poll_reg     <= poll_next;
            swap_reg     <= swap_next;
            lost_reg     <= lost_next;
            conn_reg     <= link_up_next;
            live_reg     <= live_flag_next;
            good_out_reg <= good_total_next;
            bad_out_reg  <= bad_total_next;
            run_out_reg  <= bad_run_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_line_event     = event_reg;
    assign m_packet_kind    = kind_reg;
    assign m_poll_request   = poll_reg;
    assign m_swap_request   = swap_reg;
    assign m_link_lost      = lost_reg;
    assign m_connected      = conn_reg;
    assign m_status_live    = live_reg;
    assign m_good_count     = good_out_reg;
    assign m_bad_count      = bad_out_reg;
    assign m_bad_since_good = run_out_reg;

    // A valid packet always leaves the link connected with no bad run
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_line_event == EV_GOOD) |-> (m_connected && m_bad_since_good == 32'd0))
        else $error("valid packet result without connected link");

    // Live status implies a connected link
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status_live) |-> m_connected)
        else $error("status live while disconnected");

    // The pin swap probe fires once and leaves the link down
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_swap_request) |-> (!m_connected && !m_link_lost && probe_done_reg))
        else $error("swap probe result inconsistent");

    // Once done, the probe never rearms
    assert property (@(posedge aclk) disable iff (!aresetn)
        probe_done_reg |=> probe_done_reg)
        else $error("probe done flag cleared");

endmodule

[dv/line_packet_link_monitor_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for line_packet_link_monitor: directed and random bytes and ticks.
// Depends on lplm_pkg and the RTL only; a scoreboard class tracks the expected status items.

module line_packet_link_monitor_tb;
    import lplm_pkg::*;

    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam int         LEN_BITS    = LINE_LEN_BITS_DEF;
    localparam int         PHASE_ITEMS = 85;
    localparam int         MAX_PRINTED = 30;
    localparam int         DRAIN_LIMIT = 2000;

    // One status item, fields in port order
    typedef struct packed {
        logic [1:0]  line_event;
        logic [1:0]  packet_kind;
        logic        poll_request;
        logic        swap_request;
        logic        link_lost;
        logic        connected;
        logic        status_live;
        logic [31:0] good_count;
        logic [31:0] bad_count;
        logic [31:0] bad_since_good;
    } status_t;

    typedef logic [7:0] text_t[$];

    // Tracks line assembly and link timers, and holds the status items still owed
    class packet_line_tracker;
        logic [MAX_LEN_W-1:0] max_len;
        logic [TICK_W-1:0]    timeout;
        logic [TICK_W-1:0]    poll_period;
        logic [LEN_BITS-1:0]  line_len;
        logic                 noise, content, colon;
        logic [23:0]          type_word;
        logic [2:0]           type_cnt;
        logic [31:0]          since_start, since_good;
        logic [15:0]          since_poll;
        logic                 ever_good, no_link_sent, probe_done, link_up, live;
        logic [31:0]          good_total, bad_total, bad_run;
        status_t              pending_status[$];
        int                   errors, checked;
        int                   n_good, n_bad, n_poll, n_swap, n_lost;

        function new();
            max_len     = MAX_LEN_RESET;
            timeout     = TIMEOUT_RESET;
            poll_period = POLL_RESET;
            clear_line();
            noise        = 1'b0;
            since_start  = '0;
            since_good   = '0;
            since_poll   = '0;
            ever_good    = 1'b0;
            no_link_sent = 1'b0;
            probe_done   = 1'b0;
            link_up      = 1'b0;
            live         = 1'b0;
            good_total   = '0;
            bad_total    = '0;
            bad_run      = '0;
            errors       = 0;
            checked      = 0;
            n_good       = 0;
            n_bad        = 0;
            n_poll       = 0;
            n_swap       = 0;
            n_lost       = 0;
        endfunction

        function void clear_line();
            line_len  = '0;
            content   = 1'b0;
            colon     = 1'b0;
            type_word = '0;
            type_cnt  = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MAX_LINE_LENGTH: max_len = data[MAX_LEN_W-1:0];
                CFG_TIMEOUT_TICKS:   timeout = data[TICK_W-1:0];
                CFG_POLL_PERIOD:     poll_period = data[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance on one accepted item and queue the status it should produce
        function void take_item(logic req, logic [7:0] b);
            status_t    s;
            logic       ok;
            logic [1:0] k;
            s = '0;
            if (req == REQ_BYTE) begin
                if (b == CH_LF) begin
                    // close the line: match the type word, then count it
                    ok = colon && (type_cnt == 3);
                    k  = KIND_STS;
                    if (type_word == WORD_ACK) k = KIND_ACK;
                    else if (type_word == WORD_ERR) k = KIND_ERR;
                    else if (type_word == WORD_ALM) k = KIND_ALM;
                    else if (type_word != WORD_STS) ok = 1'b0;
                    if (content && !noise && ok) begin
                        since_good   = '0;
                        ever_good    = 1'b1;
                        bad_run      = '0;
                        no_link_sent = 1'b0;
                        link_up      = 1'b1;
                        if (k == KIND_STS) live = 1'b1;
                        good_total++;
                        s.line_event  = EV_GOOD;
                        s.packet_kind = k;
                        n_good++;
                    end else if (content || noise) begin
                        bad_run++;
                        bad_total++;
                        s.line_event = EV_BAD;
                        n_bad++;
                    end
                    clear_line();
                    noise = 1'b0;
                end else if (b == CH_CR) begin
                    // carriage return is dropped
                end else if (b < CH_SPACE || b > CH_PRINT_MAX) begin
                    noise = 1'b1;
                end else if (line_len >= max_len || line_len == '1) begin
                    // overflow wipes the line and marks it noisy
                    clear_line();
                    noise = 1'b1;
                end else begin
                    line_len++;
                    // leading spaces take room but start no content
                    if (content || b != CH_SPACE) begin
                        content = 1'b1;
                        if (!colon) begin
                            if (b == CH_COLON) begin
                                colon = 1'b1;
                            end else begin
                                if (type_cnt < 3) type_word = {type_word[15:0], b};
                                if (type_cnt < 4) type_cnt++;
                            end
                        end
                    end
                end
            end else begin
                // advance saturating timers
                if (since_start != '1) since_start++;
                if (since_good != '1) since_good++;
                if (since_poll != '1) since_poll++;
                if (since_poll >= poll_period) begin
                    since_poll       = '0;
                    s.poll_request   = 1'b1;
                    n_poll++;
                end
                // one-time swapped-pin probe
                if (!probe_done && !ever_good && since_start >= {timeout, 1'b0}) begin
                    probe_done = 1'b1;
                    clear_line();
                    noise          = 1'b0;
                    bad_run        = '0;
                    ever_good      = 1'b0;
                    since_start    = '0;
                    no_link_sent   = 1'b0;
                    link_up        = 1'b0;
                    live           = 1'b0;
                    s.swap_request = 1'b1;
                    n_swap++;
                end
                if (!ever_good) begin
                    if (!no_link_sent && since_start > timeout) begin
                        no_link_sent = 1'b1;
                        link_up      = 1'b0;
                        live         = 1'b0;
                        s.link_lost  = 1'b1;
                    end
                end else if (since_good > timeout && link_up) begin
                    link_up     = 1'b0;
                    live        = 1'b0;
                    s.link_lost = 1'b1;
                end
                if (s.link_lost) n_lost++;
            end
            s.connected      = link_up;
            s.status_live    = live;
            s.good_count     = good_total;
            s.bad_count      = bad_total;
            s.bad_since_good = bad_run;
            pending_status.push_back(s);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED) $display("MISMATCH: %s", msg);
        endtask

        task match_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("status %0d %s: got 0x%0h, want 0x%0h",
                                 checked, name, got, want));
        endtask

        task check_status(status_t got);
            status_t want;
            if (pending_status.size() == 0) begin
                report("status item arrived with nothing owed");
                return;
            end
            want = pending_status.pop_front();
            match_field("line_event", got.line_event, want.line_event);
            match_field("packet_kind", got.packet_kind, want.packet_kind);
            match_field("poll_request", got.poll_request, want.poll_request);
            match_field("swap_request", got.swap_request, want.swap_request);
            match_field("link_lost", got.link_lost, want.link_lost);
            match_field("connected", got.connected, want.connected);
            match_field("status_live", got.status_live, want.status_live);
            match_field("good_count", got.good_count, want.good_count);
            match_field("bad_count", got.bad_count, want.bad_count);
            match_field("bad_since_good", got.bad_since_good, want.bad_since_good);
            checked++;
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_req_type;
    logic [7:0]            s_rx_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic [1:0]            m_line_event;
    logic [1:0]            m_packet_kind;
    logic                  m_poll_request;
    logic                  m_swap_request;
    logic                  m_link_lost;
    logic                  m_connected;
    logic                  m_status_live;
    logic [31:0]           m_good_count;
    logic [31:0]           m_bad_count;
    logic [31:0]           m_bad_since_good;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    packet_line_tracker tracker;
    int                 idle_pct;
    int                 stall_pct;
    int                 items_sent;

    line_packet_link_monitor u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_line_event     (m_line_event),
        .m_packet_kind    (m_packet_kind),
        .m_poll_request   (m_poll_request),
        .m_swap_request   (m_swap_request),
        .m_link_lost      (m_link_lost),
        .m_connected      (m_connected),
        .m_status_live    (m_status_live),
        .m_good_count     (m_good_count),
        .m_bad_count      (m_bad_count),
        .m_bad_since_good (m_bad_since_good),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Check each accepted status item, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_status({m_line_event, m_packet_kind, m_poll_request,
                                  m_swap_request, m_link_lost, m_connected,
                                  m_status_live, m_good_count, m_bad_count,
                                  m_bad_since_good});
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Hold an item on the input channel until it is taken
    task automatic send_item(logic req, logic [7:0] b);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_rx_byte  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.take_item(req, b);
        items_sent++;
    endtask

    task automatic send_text(text_t t, bit mix_ticks);
        foreach (t[i]) begin
            if (mix_ticks && $urandom_range(0, 99) < 6) send_item(REQ_TICK, 8'($urandom));
            send_item(REQ_BYTE, t[i]);
        end
    endtask

    function automatic logic [23:0] pick_word();
        case ($urandom_range(0, 3))
            0:       return WORD_STS;
            1:       return WORD_ACK;
            2:       return WORD_ERR;
            default: return WORD_ALM;
        endcase
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        if ($urandom_range(0, 1)) begin
            b = 8'($urandom_range(CH_PRINT_MAX + 1, 255));
        end else begin
            b = 8'($urandom_range(0, CH_SPACE - 1));
            if (b == CH_LF || b == CH_CR) b = '0;
        end
        return b;
    endfunction

    // Build one line: mostly packets with random payload, plus near misses and junk
    task automatic send_line();
        text_t       t;
        int          pick;
        int          n;
        logic [23:0] w;
        pick = $urandom_range(0, 99);
        repeat ($urandom_range(0, 2)) t.push_back(CH_SPACE);
        if (pick >= 88) begin
            // printable run, around the length limit when that limit is at most 40
            n = (tracker.max_len > 40) ? 44 : tracker.max_len + 4;
            repeat ($urandom_range(0, n)) t.push_back(8'($urandom_range(CH_SPACE, CH_PRINT_MAX)));
        end else if (pick >= 80) begin
            // blank line, sometimes noisy
            repeat ($urandom_range(0, 3)) t.push_back(CH_SPACE);
            if ($urandom_range(0, 1)) t.insert($urandom_range(0, t.size()), noise_byte());
        end else begin
            if (pick < 60 || pick >= 72) begin
                w = pick_word();
                t.push_back(w[23:16]);
                t.push_back(w[15:8]);
                t.push_back(w[7:0]);
            end else begin
                // near-miss type word made of packet letters
                repeat ($urandom_range(1, 4)) begin
                    w = pick_word();
                    t.push_back(w[8 * $urandom_range(0, 2) +: 8]);
                end
            end
            if (pick < 60 || $urandom_range(0, 3) != 0) t.push_back(CH_COLON);
            repeat ($urandom_range(0, 6)) t.push_back(8'($urandom_range(CH_SPACE, CH_PRINT_MAX)));
            repeat ($urandom_range(0, 2)) t.push_back(CH_SPACE);
            if (pick >= 72) t.insert($urandom_range(0, t.size()), noise_byte());
        end
        if ($urandom_range(0, 2) == 0) t.push_back(CH_CR);
        t.push_back(CH_LF);
        send_text(t, 1'b1);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.write_reg(idx, data);
    endtask

    // Load all registers; unused upper bits and the spare index carry random data
    task automatic set_config(int ml, int to, int pp);
        write_reg(CFG_UNUSED, 16'($urandom));
        write_reg(CFG_MAX_LINE_LENGTH, {6'($urandom), 10'(ml)});
        write_reg(CFG_TIMEOUT_TICKS, 16'(to));
        write_reg(CFG_POLL_PERIOD, 16'(pp));
        cfg_valid <= 1'b0;
    endtask

    // Wait for every owed status item, then let the pipeline settle
    task automatic drain();
        int n;
        n = 0;
        while (tracker.pending_status.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        if (tracker.pending_status.size() != 0) begin
            tracker.report($sformatf("%0d status items never arrived",
                                     tracker.pending_status.size()));
            tracker.pending_status.delete();
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_phase(int ml, int to, int pp, int idle, int stall, int burst, bit pause);
        int  start;
        int  pick;
        bit  paused;
        start  = items_sent;
        paused = 1'b0;
        set_config(ml, to, pp);
        idle_pct  = idle;
        stall_pct = stall;
        while (items_sent - start < PHASE_ITEMS) begin
            if (pause && !paused && items_sent - start >= PHASE_ITEMS / 2) begin
                // hold off until the block has nothing left to report
                paused  = 1'b1;
                s_valid <= 1'b0;
                do @(posedge aclk); while (tracker.pending_status.size() != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) send_line();
            else if (pick < 85) repeat ($urandom_range(1, burst)) send_item(REQ_TICK, 8'($urandom));
            else send_item(REQ_BYTE, 8'($urandom_range(0, 255)));
        end
        s_valid <= 1'b0;
        drain();
    endtask

    initial begin
        text_t t;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_req_type = REQ_BYTE;
        s_rx_byte  = '0;
        m_ready    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_MAX_LINE_LENGTH;
        cfg_data   = '0;
        idle_pct   = 0;
        stall_pct  = 0;
        items_sent = 0;
        tracker    = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: no-link report, pin probe, clean and noisy lines, timeout after a packet
        set_config(6, 2, 1);
        repeat (4) send_item(REQ_TICK, 8'($urandom));
        t = '{WORD_STS[23:16], WORD_STS[15:8], WORD_STS[7:0], CH_COLON, CH_CR, CH_LF};
        send_text(t, 1'b0);
        t = '{8'h00, CH_LF};
        send_text(t, 1'b0);
        t = '{CH_SPACE, CH_LF};
        send_text(t, 1'b0);
        t = '{WORD_ERR[23:16], WORD_ERR[15:8], WORD_ERR[7:0], CH_LF};
        send_text(t, 1'b0);
        t = '{8'hFF, CH_LF};
        send_text(t, 1'b0);
        repeat (3) send_item(REQ_TICK, 8'($urandom));
        s_valid <= 1'b0;
        drain();

        // Random: register extremes and mid settings across the idling mixes
        run_phase(1023, 65535, 65535, 0, 0, 8, 1'b0);
        run_phase(3, 5, 3, 54, 0, 8, 1'b0);
        run_phase(0, 0, 0, 0, 54, 4, 1'b0);
        run_phase(12, 9, 7, 38, 38, 12, 1'b1);
        run_phase(40, 20, 1, 54, 54, 24, 1'b0);
        run_phase(1, 1, 65535, 38, 38, 4, 1'b0);

        $display("Sent %0d bytes and ticks over seven register settings; %0d items checked.",
                 items_sent, tracker.checked);
        $display("Saw %0d good lines, %0d bad lines, %0d polls, %0d pin swaps, %0d link drops.",
                 tracker.n_good, tracker.n_bad, tracker.n_poll, tracker.n_swap, tracker.n_lost);
        if (tracker.errors == 0) begin
            $display("line_packet_link_monitor_tb: clean");
        end else begin
            $display("line_packet_link_monitor_tb: errors");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #400_000;
        $display("line_packet_link_monitor_tb: errors");
        $finish;
    end

endmodule
